@@ rtl/asra_pkg.sv @@
package asra_pkg;

    localparam int PageSize  = 1024;
    localparam int MaxPages  = 8;
    localparam int MaxFrames = 256;

    localparam int SLOT_W  = 8;
    localparam int PAGE_W  = 3;
    localparam int COORD_W = 10;
    localparam int ROW_W   = 11;
    localparam int AREA_W  = 21;
    localparam int CNT_W   = 4;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_PAGE  = 2'd1;
    localparam logic [1:0] ST_BAD_SLOT = 2'd2;

    typedef struct packed {
        logic               command;
        logic [SLOT_W-1:0]  frame_slot;
        logic [COORD_W-1:0] rect_width;
        logic [COORD_W-1:0] rect_height;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [PAGE_W-1:0]  page_index;
        logic [COORD_W-1:0] placed_left;
        logic [COORD_W-1:0] placed_top;
        logic               page_released;
        logic [CNT_W-1:0]   pages_live;
    } out_item_t;

    // frame record: page, rect, links
    typedef struct packed {
        logic [PAGE_W-1:0]  page;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] height;
        logic               has_prev;
        logic [SLOT_W-1:0]  prev;
        logic               has_next;
        logic [SLOT_W-1:0]  next;
    } frame_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_SLOT,
        S_RD_NBR,
        S_EXEC,
        S_WR_NBR2,
        S_OUT
    } state_t;

endpackage

@@ rtl/atlas_shelf_rect_allocator.sv @@
// result: the item is registered, then passes the slot read, neighbor read, execute and
// second link write states before the result goes valid; one item in flight at a time
// a new item is not taken until the result of the last one has been handed over and the
// block is back in idle, so a stall on the result side holds off the input
// reset: page table, counters and frame busy bits are cleared synchronously; frame
// records are not cleared and are only used for busy slots
module atlas_shelf_rect_allocator (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  asra_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output asra_pkg::out_item_t  m_data
);

    localparam int NP = asra_pkg::MaxPages;

    asra_pkg::state_t state_reg, state_next;
    asra_pkg::in_item_t item_reg;

    logic [NP-1:0]                    live_reg;
    logic [asra_pkg::ROW_W-1:0]       row_top_reg [NP];
    logic [asra_pkg::ROW_W-1:0]       row_bot_reg [NP];
    logic [asra_pkg::SLOT_W-1:0]      last_reg    [NP];
    logic [NP-1:0]                    has_last_reg;
    logic [asra_pkg::AREA_W-1:0]      area_reg    [NP];
    logic [asra_pkg::CNT_W-1:0]       live_cnt_reg, opened_reg;
    logic [asra_pkg::MaxFrames-1:0]   busy_reg;

    // frame table memory
    asra_pkg::frame_t frame_mem [asra_pkg::MaxFrames];
    logic                          mem_we;
    logic [asra_pkg::SLOT_W-1:0]   mem_waddr, mem_raddr;
    asra_pkg::frame_t              mem_wdata, mem_rdata;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            frame_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata <= frame_mem[mem_raddr];
    end

    asra_pkg::frame_t slot_rec_reg, nbr_rec_reg;
    asra_pkg::out_item_t out_reg, out_next;
    logic out_valid_reg;
    logic [asra_pkg::SLOT_W-1:0] nbr2_addr_reg, nbr2_addr_next;
    asra_pkg::frame_t nbr2_data_reg, nbr2_data_next;
    logic nbr2_we_reg, nbr2_we_next;

    assign s_ready = (state_reg == asra_pkg::S_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // decode and combinational execute
    logic                        is_free, slot_bad, size_bad, alloc_ok;
    logic [asra_pkg::PAGE_W-1:0] b_page, fp, dead_page;
    logic                        dead_found;
    logic [asra_pkg::SLOT_W-1:0] nbr_addr;

    logic [asra_pkg::ROW_W+1:0] lr, ftop_h, rt, rb, hh, ww;
    logic                       fit_b, fit_new, append;
    logic [asra_pkg::PAGE_W-1:0] sel_page;
    logic [asra_pkg::ROW_W+1:0] p_left, p_top, p_nt, p_nb;
    logic                       use_b;
    logic [asra_pkg::AREA_W-1:0] rect_area, free_area, area_left;
    asra_pkg::frame_t            new_rec, prev_rec;

    always_comb begin
        is_free  = (item_reg.command == asra_pkg::CMD_FREE);
        slot_bad = (busy_reg[item_reg.frame_slot] != is_free);
        size_bad = (item_reg.rect_width == '0) || (item_reg.rect_height == '0);
        b_page   = asra_pkg::PAGE_W'(opened_reg - 1'b1);
        dead_page  = '0;
        dead_found = 1'b0;
        for (int i = NP - 1; i >= 0; i--) begin
            if (!live_reg[i] && (asra_pkg::CNT_W'(i) < opened_reg)) begin
                dead_page  = asra_pkg::PAGE_W'(i);
                dead_found = 1'b1;
            end
        end
        fp = slot_rec_reg.page;
        // slot record is on the read port while the neighbor read is issued
        if (is_free) begin
            nbr_addr = mem_rdata.prev;
        end else begin
            nbr_addr = last_reg[b_page];
        end

        // placement on last opened page; nbr_rec_reg holds its last frame
        ww = {3'd0, item_reg.rect_width};
        hh = {3'd0, item_reg.rect_height};
        rt = {2'd0, row_top_reg[b_page]};
        rb = {2'd0, row_bot_reg[b_page]};
        lr = {3'd0, nbr_rec_reg.left} + {3'd0, nbr_rec_reg.width};
        ftop_h = {3'd0, nbr_rec_reg.top} + {3'd0, nbr_rec_reg.height};
        p_left = '0;
        p_top  = '0;
        p_nt   = rt;
        p_nb   = hh;
        fit_b  = 1'b1;
        if (has_last_reg[b_page]) begin
            if (nbr_rec_reg.width >= item_reg.rect_width && ftop_h + hh <= rb) begin
                p_left = lr - ww;
                p_top  = ftop_h;
                p_nb   = rb;
            end else if (lr + ww <= 13'(asra_pkg::PageSize)) begin
                p_left = lr;
                p_top  = rt;
                p_nb   = (rt + hh > rb) ? rt + hh : rb;
                fit_b  = (rt + hh <= 13'(asra_pkg::PageSize));
            end else begin
                p_nt  = rb;
                p_top = rb;
                p_nb  = rb + hh;
                fit_b = (rb + hh <= 13'(asra_pkg::PageSize));
            end
        end
        use_b = (live_cnt_reg != '0) && (opened_reg != '0) && live_reg[b_page] && fit_b;
        append = ({1'b0, live_cnt_reg} >= 5'(({1'b0, opened_reg} * 5'd2) / 5'd4))
                 && (opened_reg < asra_pkg::CNT_W'(NP));
        fit_new = append || dead_found;
        sel_page = use_b ? b_page : (append ? asra_pkg::PAGE_W'(opened_reg) : dead_page);
        if (!use_b) begin
            p_left = '0;
            p_top  = '0;
            p_nt   = '0;
            p_nb   = hh;
        end
        alloc_ok  = !slot_bad && !is_free && !size_bad && (use_b || fit_new);
        rect_area = {11'd0, item_reg.rect_width} * {11'd0, item_reg.rect_height};
        free_area = {11'd0, slot_rec_reg.width} * {11'd0, slot_rec_reg.height};
        area_left = (area_reg[fp] >= free_area) ? area_reg[fp] - free_area : '0;

        new_rec          = '0;
        new_rec.page     = sel_page;
        new_rec.left     = asra_pkg::COORD_W'(p_left);
        new_rec.top      = asra_pkg::COORD_W'(p_top);
        new_rec.width    = item_reg.rect_width;
        new_rec.height   = item_reg.rect_height;
        new_rec.has_prev = use_b && has_last_reg[sel_page];
        new_rec.prev     = use_b ? last_reg[sel_page] : '0;

        prev_rec          = nbr_rec_reg;
        prev_rec.has_next = slot_rec_reg.has_next;
        prev_rec.next     = slot_rec_reg.next;

        // second link write: old last frame on alloc, next frame on free
        nbr2_addr_next          = last_reg[b_page];
        nbr2_data_next          = nbr_rec_reg;
        nbr2_data_next.has_next = 1'b1;
        nbr2_data_next.next     = item_reg.frame_slot;
        if (is_free) begin
            // next frame record was read in the neighbor read state
            nbr2_we_next            = !slot_bad && slot_rec_reg.has_next;
            nbr2_addr_next          = slot_rec_reg.next;
            nbr2_data_next          = mem_rdata;
            nbr2_data_next.has_prev = slot_rec_reg.has_prev;
            nbr2_data_next.prev     = slot_rec_reg.prev;
        end else begin
            nbr2_we_next = alloc_ok && use_b && has_last_reg[b_page];
        end

        out_next            = '0;
        out_next.pages_live = live_cnt_reg;
        if (slot_bad) begin
            out_next.status = asra_pkg::ST_BAD_SLOT;
        end else if (!is_free) begin
            if (!alloc_ok) begin
                out_next.status = asra_pkg::ST_NO_PAGE;
            end else begin
                if (!use_b) out_next.pages_live = live_cnt_reg + 1'b1;
                out_next.page_index  = sel_page;
                out_next.placed_left = asra_pkg::COORD_W'(p_left);
                out_next.placed_top  = asra_pkg::COORD_W'(p_top);
            end
        end else begin
            out_next.page_index  = fp;
            out_next.placed_left = slot_rec_reg.left;
            out_next.placed_top  = slot_rec_reg.top;
            if (area_left == '0) begin
                if (live_reg[fp] && live_cnt_reg != '0) begin
                    out_next.pages_live = live_cnt_reg - 1'b1;
                end
                out_next.page_released = 1'b1;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        mem_raddr  = item_reg.frame_slot;
        mem_we     = 1'b0;
        mem_waddr  = item_reg.frame_slot;
        mem_wdata  = new_rec;
        case (state_reg)
            asra_pkg::S_IDLE: begin
                mem_raddr = s_data.frame_slot;
                if (s_valid) state_next = asra_pkg::S_RD_SLOT;
            end
            asra_pkg::S_RD_SLOT: begin
                mem_raddr  = nbr_addr;
                state_next = asra_pkg::S_RD_NBR;
            end
            asra_pkg::S_RD_NBR: begin
                mem_raddr  = slot_rec_reg.next;
                state_next = asra_pkg::S_EXEC;
            end
            asra_pkg::S_EXEC: begin
                if (is_free) begin
                    mem_we    = !slot_bad && slot_rec_reg.has_prev;
                    mem_waddr = slot_rec_reg.prev;
                    mem_wdata = prev_rec;
                end else begin
                    mem_we = alloc_ok;
                end
                state_next = asra_pkg::S_WR_NBR2;
            end
            asra_pkg::S_WR_NBR2: begin
                mem_we     = nbr2_we_reg;
                mem_waddr  = nbr2_addr_reg;
                mem_wdata  = nbr2_data_reg;
                state_next = asra_pkg::S_OUT;
            end
            asra_pkg::S_OUT: begin
                if (!out_valid_reg) state_next = asra_pkg::S_IDLE;
            end
            default: state_next = asra_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= asra_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            live_reg      <= '0;
            has_last_reg  <= '0;
            live_cnt_reg  <= '0;
            opened_reg    <= '0;
            busy_reg      <= '0;
            nbr2_we_reg   <= 1'b0;
            for (int i = 0; i < NP; i++) begin
                row_top_reg[i] <= '0;
                row_bot_reg[i] <= '0;
                last_reg[i]    <= '0;
                area_reg[i]    <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (state_reg == asra_pkg::S_WR_NBR2) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                asra_pkg::S_IDLE: begin
                    if (s_valid) item_reg <= s_data;
                end
                asra_pkg::S_RD_SLOT: slot_rec_reg <= mem_rdata;
                asra_pkg::S_RD_NBR:  nbr_rec_reg <= mem_rdata;
                asra_pkg::S_EXEC: begin
                    out_reg       <= out_next;
                    nbr2_we_reg   <= nbr2_we_next;
                    nbr2_addr_reg <= nbr2_addr_next;
                    nbr2_data_reg <= nbr2_data_next;
                    if (alloc_ok) begin
                        if (!use_b) begin
                            if (append) opened_reg <= opened_reg + 1'b1;
                            live_reg[sel_page] <= 1'b1;
                            live_cnt_reg <= live_cnt_reg + 1'b1;
                        end
                        busy_reg[item_reg.frame_slot] <= 1'b1;
                        last_reg[sel_page]     <= item_reg.frame_slot;
                        has_last_reg[sel_page] <= 1'b1;
                        row_top_reg[sel_page]  <= asra_pkg::ROW_W'(p_nt);
                        row_bot_reg[sel_page]  <= asra_pkg::ROW_W'(p_nb);
                        area_reg[sel_page] <= (use_b ? area_reg[sel_page] : '0)
                                              + rect_area;
                    end else if (is_free && !slot_bad) begin
                        busy_reg[item_reg.frame_slot] <= 1'b0;
                        area_reg[fp] <= area_left;
                        if (area_left == '0) begin
                            if (live_reg[fp] && live_cnt_reg != '0) begin
                                live_cnt_reg <= live_cnt_reg - 1'b1;
                            end
                            live_reg[fp] <= 1'b0;
                        end else if (has_last_reg[fp] && last_reg[fp] == item_reg.frame_slot)
                        begin
                            has_last_reg[fp] <= slot_rec_reg.has_prev;
                            last_reg[fp] <= slot_rec_reg.has_prev ? slot_rec_reg.prev : '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while result pending");
    a_live_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        live_cnt_reg <= opened_reg)
        else $error("live pages exceed opened pages");
`endif

endmodule

@@ tb/sv/atlas_shelf_rect_allocator_tb.sv @@
`timescale 1ns / 100ps

module atlas_shelf_rect_allocator_tb;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    asra_pkg::in_item_t  s_data;
    logic                m_valid;
    logic                m_ready;
    asra_pkg::out_item_t m_data;

    atlas_shelf_rect_allocator uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // allocator shadow state
    logic                         sh_live [asra_pkg::MaxPages];
    logic [asra_pkg::ROW_W-1:0]   sh_row_top [asra_pkg::MaxPages];
    logic [asra_pkg::ROW_W-1:0]   sh_row_bot [asra_pkg::MaxPages];
    logic [asra_pkg::SLOT_W-1:0]  sh_last [asra_pkg::MaxPages];
    logic                         sh_has_last [asra_pkg::MaxPages];
    logic [asra_pkg::AREA_W-1:0]  sh_area [asra_pkg::MaxPages];
    int unsigned                  sh_live_cnt;
    int unsigned                  sh_open_cnt;
    logic                         sh_busy [asra_pkg::MaxFrames];
    asra_pkg::frame_t             sh_frame [asra_pkg::MaxFrames];

    asra_pkg::out_item_t placement_q[$];
    int        errors;
    int        n_released, n_no_page, n_bad_slot;
    bit        quiet;

    // try shelf placement on page p
    function automatic bit shelf_fit(input int p, input int w, input int h,
                                     output int left, output int top,
                                     output int nt, output int nb);
        int rt, rb, lr, ftop;
        asra_pkg::frame_t f;
        rt = int'(sh_row_top[p]);
        rb = int'(sh_row_bot[p]);
        left = 0; top = 0; nt = rt; nb = h;
        if (!sh_has_last[p]) return 1'b1;
        f = sh_frame[sh_last[p]];
        lr = int'(f.left) + int'(f.width);
        ftop = int'(f.top) + int'(f.height);
        if (int'(f.width) >= w && ftop + h <= rb) begin
            left = lr - w;
            top = ftop;
            nb = rb;
            return 1'b1;
        end
        if (lr + w <= asra_pkg::PageSize) begin
            left = lr; top = rt;
            nb = (rt + h > rb) ? rt + h : rb;
            return rt + h <= asra_pkg::PageSize;
        end
        nt = rb; top = rb; nb = rb + h;
        return rb + h <= asra_pkg::PageSize;
    endfunction

    function automatic void shadow_reset();
        for (int i = 0; i < asra_pkg::MaxPages; i++) begin
            sh_live[i] = 0; sh_row_top[i] = 0; sh_row_bot[i] = 0;
            sh_last[i] = 0; sh_has_last[i] = 0; sh_area[i] = 0;
        end
        for (int i = 0; i < asra_pkg::MaxFrames; i++) begin
            sh_busy[i] = 0;
            sh_frame[i] = '0;
        end
        sh_live_cnt = 0;
        sh_open_cnt = 0;
    endfunction

    function automatic asra_pkg::out_item_t predict_placement(input asra_pkg::in_item_t it);
        asra_pkg::out_item_t r;
        int w, h, p, left, top, nt, nb, b, area, s;
        asra_pkg::frame_t f;
        r = '0;
        w = int'(it.rect_width);
        h = int'(it.rect_height);
        s = int'(it.frame_slot);
        if (sh_busy[s] != (it.command == asra_pkg::CMD_FREE)) begin
            r.status = asra_pkg::ST_BAD_SLOT;
        end else if (it.command == asra_pkg::CMD_ALLOC) begin
            p = -1;
            left = 0; top = 0; nt = 0; nb = 0;
            if (w == 0 || h == 0) begin
                r.status = asra_pkg::ST_NO_PAGE;
            end else begin
                if (sh_live_cnt > 0 && sh_open_cnt > 0) begin
                    b = int'((sh_open_cnt - 1) % asra_pkg::MaxPages);
                    if (sh_live[b] && shelf_fit(b, w, h, left, top, nt, nb)) p = b;
                end
                if (p < 0) begin
                    if (sh_live_cnt >= sh_open_cnt * 2 / 4 &&
                        sh_open_cnt < asra_pkg::MaxPages) begin
                        p = int'(sh_open_cnt);
                        sh_open_cnt++;
                    end else begin
                        for (int i = 0; i < int'(sh_open_cnt) && i < asra_pkg::MaxPages; i++)
                            if (p < 0 && !sh_live[i]) p = i;
                    end
                    if (p >= 0) begin
                        sh_live[p] = 1; sh_row_top[p] = 0; sh_row_bot[p] = 0;
                        sh_last[p] = 0; sh_has_last[p] = 0; sh_area[p] = 0;
                        sh_live_cnt++;
                        void'(shelf_fit(p, w, h, left, top, nt, nb));
                    end else begin
                        r.status = asra_pkg::ST_NO_PAGE;
                    end
                end
            end
            if (r.status == asra_pkg::ST_OK) begin
                if (sh_has_last[p]) begin
                    sh_frame[sh_last[p]].has_next = 1'b1;
                    sh_frame[sh_last[p]].next = asra_pkg::SLOT_W'(s);
                end
                f = '0;
                f.page     = asra_pkg::PAGE_W'(p);
                f.left     = asra_pkg::COORD_W'(left);
                f.top      = asra_pkg::COORD_W'(top);
                f.width    = asra_pkg::COORD_W'(w);
                f.height   = asra_pkg::COORD_W'(h);
                f.has_prev = sh_has_last[p];
                f.prev     = sh_last[p];
                sh_frame[s] = f;
                sh_busy[s] = 1;
                sh_last[p] = asra_pkg::SLOT_W'(s);
                sh_has_last[p] = 1;
                sh_row_top[p] = asra_pkg::ROW_W'(nt);
                sh_row_bot[p] = asra_pkg::ROW_W'(nb);
                sh_area[p] = sh_area[p] + asra_pkg::AREA_W'(w * h);
                r.page_index  = asra_pkg::PAGE_W'(p);
                r.placed_left = asra_pkg::COORD_W'(left);
                r.placed_top  = asra_pkg::COORD_W'(top);
            end
        end else begin
            f = sh_frame[s];
            p = int'(f.page);
            area = int'(f.width) * int'(f.height);
            if (f.has_prev) begin
                sh_frame[f.prev].has_next = f.has_next;
                sh_frame[f.prev].next = f.next;
            end
            if (f.has_next) begin
                sh_frame[f.next].has_prev = f.has_prev;
                sh_frame[f.next].prev = f.prev;
            end
            sh_busy[s] = 0;
            r.page_index = f.page; r.placed_left = f.left; r.placed_top = f.top;
            sh_area[p] = (int'(sh_area[p]) >= area) ?
                         sh_area[p] - asra_pkg::AREA_W'(area) : '0;
            if (sh_area[p] == 0) begin
                if (sh_live[p] && sh_live_cnt > 0) sh_live_cnt--;
                sh_live[p] = 0;
                r.page_released = 1'b1;
            end else if (sh_has_last[p] && int'(sh_last[p]) == s) begin
                sh_has_last[p] = f.has_prev;
                sh_last[p] = f.has_prev ? f.prev : '0;
            end
        end
        r.pages_live = asra_pkg::CNT_W'(sh_live_cnt);
        return r;
    endfunction

    // drive one item; the expectation is the typed-in one when fixed is set
    task automatic send_item(input asra_pkg::in_item_t it, input bit fixed,
                             input asra_pkg::out_item_t fixed_res);
        asra_pkg::out_item_t pred;
        @(negedge aclk);
        while (!quiet && $urandom_range(99) < 33) @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= it;
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
        pred = predict_placement(it);
        placement_q.push_back(fixed ? fixed_res : pred);
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // output side: random backpressure, compare on handshake
    always @(negedge aclk) begin
        if (aresetn) m_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 33);
    end

    always @(posedge aclk) begin
        asra_pkg::out_item_t e;
        if (aresetn && m_valid && m_ready) begin
            if (placement_q.size() == 0) begin
                $display("%0t: unexpected result %p", $time, m_data);
                errors++;
            end else begin
                e = placement_q.pop_front();
                if (m_data !== e) begin
                    $display("%0t: mismatch expected %p actual %p", $time, e, m_data);
                    errors++;
                end
                case (e.status)
                    asra_pkg::ST_NO_PAGE:  n_no_page++;
                    asra_pkg::ST_BAD_SLOT: n_bad_slot++;
                    default: begin
                        if (m_data.page_released) n_released++;
                    end
                endcase
            end
        end
    end

    // directed table, fixed results only where obvious
    typedef struct {
        asra_pkg::in_item_t  it;
        bit                  fixed;
        asra_pkg::out_item_t res;
    } dir_row_t;

    function automatic asra_pkg::in_item_t mk(input logic c, input int s,
                                              input int w, input int h);
        asra_pkg::in_item_t it;
        it.command     = c;
        it.frame_slot  = asra_pkg::SLOT_W'(s);
        it.rect_width  = asra_pkg::COORD_W'(w);
        it.rect_height = asra_pkg::COORD_W'(h);
        return it;
    endfunction

    function automatic asra_pkg::out_item_t fixed_out(input logic [1:0] st, input int pl);
        asra_pkg::out_item_t r;
        r = '0;
        r.status = st;
        r.pages_live = asra_pkg::CNT_W'(pl);
        return r;
    endfunction

    task automatic run_directed();
        dir_row_t rows[$];
        rows.push_back('{mk(asra_pkg::CMD_FREE, 0, 5, 5), 1'b1,
                         fixed_out(asra_pkg::ST_BAD_SLOT, 0)});
        rows.push_back('{mk(asra_pkg::CMD_ALLOC, 1, 0, 7), 1'b1,
                         fixed_out(asra_pkg::ST_NO_PAGE, 0)});
        rows.push_back('{mk(asra_pkg::CMD_ALLOC, 1, 9, 0), 1'b1,
                         fixed_out(asra_pkg::ST_NO_PAGE, 0)});
        rows.push_back('{mk(asra_pkg::CMD_ALLOC, 0, 1023, 1023), 1'b1,
                         fixed_out(asra_pkg::ST_OK, 1)});
        rows.push_back('{mk(asra_pkg::CMD_ALLOC, 0, 3, 3), 1'b1,
                         fixed_out(asra_pkg::ST_BAD_SLOT, 1)});
        rows.push_back('{mk(asra_pkg::CMD_ALLOC, 255, 1, 1), 1'b0, '0});
        rows.push_back('{mk(asra_pkg::CMD_ALLOC, 2, 300, 200), 1'b0, '0});
        rows.push_back('{mk(asra_pkg::CMD_ALLOC, 3, 200, 100), 1'b0, '0});
        rows.push_back('{mk(asra_pkg::CMD_ALLOC, 4, 500, 50), 1'b0, '0});
        rows.push_back('{mk(asra_pkg::CMD_ALLOC, 5, 600, 300), 1'b0, '0});
        rows.push_back('{mk(asra_pkg::CMD_ALLOC, 6, 1, 1023), 1'b0, '0});
        rows.push_back('{mk(asra_pkg::CMD_FREE, 5, 0, 0), 1'b0, '0});
        rows.push_back('{mk(asra_pkg::CMD_ALLOC, 7, 400, 100), 1'b0, '0});
        rows.push_back('{mk(asra_pkg::CMD_FREE, 0, 1023, 1023), 1'b0, '0});
        rows.push_back('{mk(asra_pkg::CMD_FREE, 3, 0, 0), 1'b0, '0});
        rows.push_back('{mk(asra_pkg::CMD_ALLOC, 170, 682, 341), 1'b0, '0});
        rows.push_back('{mk(asra_pkg::CMD_ALLOC, 85, 341, 682), 1'b0, '0});
        for (int i = 8; i < 16; i++)
            rows.push_back('{mk(asra_pkg::CMD_ALLOC, i, 1023, 1000), 1'b0, '0});
        foreach (rows[i]) send_item(rows[i].it, rows[i].fixed, rows[i].res);
    endtask

    task automatic run_random(input int n);
        int s, w, h, r;
        for (int k = 0; k < n; k++) begin
            quiet = (k >= 300 && k < 420);
            s = int'($urandom_range(255));
            r = int'($urandom_range(99));
            if (r < 8) begin
                w = int'($urandom_range(1023)); h = int'($urandom_range(1023));
            end else if (r < 20) begin
                w = int'($urandom_range(1023, 400)); h = int'($urandom_range(1023, 300));
            end else begin
                w = int'($urandom_range(200, 1)); h = int'($urandom_range(200, 1));
            end
            // bias toward legal use of the slot so the pages fill and drain
            if ($urandom_range(99) < 85) begin
                if (sh_busy[s]) send_item(mk(asra_pkg::CMD_FREE, s, w, h), 1'b0, '0);
                else send_item(mk(asra_pkg::CMD_ALLOC, s, w, h), 1'b0, '0);
            end else begin
                send_item(mk(1'($urandom_range(1)), s, w, h), 1'b0, '0);
            end
        end
        quiet = 1'b0;
    endtask

    initial begin
        errors = 0;
        n_released = 0; n_no_page = 0; n_bad_slot = 0;
        quiet = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        m_ready = 1'b0;
        shadow_reset();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        run_directed();
        run_random(900);
        while (placement_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("covered the directed edge rows and 900 random alloc and free items");
        $display("no-page results %0d, wrong-slot results %0d, pages released %0d",
                 n_no_page, n_bad_slot, n_released);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("timeout with %0d results outstanding", placement_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
